### src/dfpwd_pkg.sv
// Shared types and constants for the DLE frame parser with wheel-count deltas.
// Used by the front, queue, back and top-level modules; depends on nothing.
package dfpwd_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int MIN_FRAME_LEN    = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TUSER_W = 2;
    localparam int OUT_TDATA_W = 160;

    localparam logic [7:0]  SYM_DLE       = 8'h10;
    localparam logic [7:0]  SYM_STX       = 8'h02;
    localparam logic [7:0]  SYM_ETX       = 8'h03;
    localparam logic [31:0] ODOM_ID_RESET = 32'h0000_0403;

    typedef enum logic [1:0] {
        PH_WAIT_DLE = 2'd0,
        PH_WAIT_STX = 2'd1,
        PH_BODY     = 2'd2,
        PH_BODY_ESC = 2'd3
    } parse_phase_t;

    typedef enum logic [1:0] {
        ST_ODOM_OK   = 2'd0,
        ST_CSUM_BAD  = 2'd1,
        ST_OTHER_ID  = 2'd2,
        ST_TOO_SHORT = 2'd3
    } frame_status_t;

    // One finished frame, classified by the front
    typedef struct packed {
        logic        too_short;
        logic        csum_bad;
        logic [31:0] message_id;
        logic [31:0] left_count;
        logic [31:0] right_count;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

endpackage

### src/dfpwd_front.sv
// Front end: byte-stuffed frame parser with running XOR and positional capture.
// Depends on dfpwd_pkg; pushes one frame record per DLE-ETX into the queue.
module dfpwd_front #(
    parameter int BUFFER_DEPTH = dfpwd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  dfpwd_pkg::queue_flags_t q_flags,
    output logic                  push,
    output dfpwd_pkg::frame_rec_t push_rec
);

    localparam int WP_W = $clog2(BUFFER_DEPTH);
    localparam logic [WP_W-1:0] WP_LIMIT = WP_W'(BUFFER_DEPTH - 1);
    localparam logic [WP_W-1:0] WP_MIN   = WP_W'(dfpwd_pkg::MIN_FRAME_LEN);

    dfpwd_pkg::parse_phase_t phase_reg, phase_next;
    logic [WP_W-1:0] wp_reg, wp_next;
    logic [7:0]      xor_reg, xor_next;
    logic [31:0]     id_reg, id_next;
    logic [31:0]     left_reg, left_next;
    logic [31:0]     right_reg, right_next;

    logic accept;
    logic store_byte;
    logic store_eff;
    logic clear_wp;
    logic frame_end;

    assign s_tready = !q_flags.full;
    assign accept   = s_tvalid && s_tready;

    // Next state
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                dfpwd_pkg::PH_WAIT_DLE: begin
                    if (s_tdata == dfpwd_pkg::SYM_DLE) phase_next = dfpwd_pkg::PH_WAIT_STX;
                end
                dfpwd_pkg::PH_WAIT_STX: begin
                    if (s_tdata == dfpwd_pkg::SYM_STX) phase_next = dfpwd_pkg::PH_BODY;
                end
                dfpwd_pkg::PH_BODY: begin
                    if (s_tdata == dfpwd_pkg::SYM_DLE) phase_next = dfpwd_pkg::PH_BODY_ESC;
                end
                dfpwd_pkg::PH_BODY_ESC: begin
                    if (s_tdata == dfpwd_pkg::SYM_ETX) phase_next = dfpwd_pkg::PH_WAIT_DLE;
                    else                               phase_next = dfpwd_pkg::PH_BODY;
                end
                default: begin
                    phase_next = dfpwd_pkg::PH_WAIT_DLE;
                end
            endcase
        end
    end

    // Outputs of the parser
    always_comb begin
        store_byte = 1'b0;
        clear_wp   = 1'b0;
        frame_end  = 1'b0;
        if (accept) begin
            case (phase_reg)
                dfpwd_pkg::PH_WAIT_STX: begin
                    clear_wp = 1'b1;
                end
                dfpwd_pkg::PH_BODY: begin
                    store_byte = (s_tdata != dfpwd_pkg::SYM_DLE);
                end
                dfpwd_pkg::PH_BODY_ESC: begin
                    store_byte = (s_tdata != dfpwd_pkg::SYM_ETX);
                    frame_end  = (s_tdata == dfpwd_pkg::SYM_ETX);
                end
                default: begin
                    store_byte = 1'b0;
                end
            endcase
        end
    end

    // Drop bytes once the store is full
    assign store_eff = store_byte && (wp_reg < WP_LIMIT);

    always_comb begin
        wp_next    = wp_reg;
        xor_next   = xor_reg;
        id_next    = id_reg;
        left_next  = left_reg;
        right_next = right_reg;
        if (clear_wp) begin
            wp_next  = '0;
            xor_next = '0;
        end else if (store_eff) begin
            wp_next  = wp_reg + WP_W'(1);
            xor_next = xor_reg ^ s_tdata;
            // Counters are byte-swapped within each 16-bit half
            case (int'(wp_reg))
                1:       id_next[7:0]      = s_tdata;
                2:       id_next[15:8]     = s_tdata;
                3:       id_next[23:16]    = s_tdata;
                4:       id_next[31:24]    = s_tdata;
                7:       left_next[15:8]   = s_tdata;
                8:       left_next[7:0]    = s_tdata;
                9:       left_next[31:24]  = s_tdata;
                10:      left_next[23:16]  = s_tdata;
                11:      right_next[15:8]  = s_tdata;
                12:      right_next[7:0]   = s_tdata;
                13:      right_next[31:24] = s_tdata;
                14:      right_next[23:16] = s_tdata;
                default: id_next           = id_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= dfpwd_pkg::PH_WAIT_DLE;
            wp_reg    <= '0;
            xor_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            wp_reg    <= wp_next;
            xor_reg   <= xor_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    // XOR over all stored bytes is zero exactly when the last byte matches the rest
    assign push                 = frame_end;
    assign push_rec.too_short   = (wp_reg < WP_MIN);
    assign push_rec.csum_bad    = (xor_reg != 8'h00);
    assign push_rec.message_id  = id_reg;
    assign push_rec.left_count  = left_reg;
    assign push_rec.right_count = right_reg;

    a_wp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= WP_LIMIT)
        else $error("write position beyond store");

    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_end |=> phase_reg == dfpwd_pkg::PH_WAIT_DLE && $stable(wp_reg))
        else $error("frame end did not return parser to idle");

    a_store_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        store_eff |=> wp_reg == $past(wp_reg) + WP_W'(1))
        else $error("stored byte did not advance position");

endmodule

### src/dfpwd_queue.sv
// Short FIFO of classified frame records between front and back.
// Depends on dfpwd_pkg for the record type and depth.
module dfpwd_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  dfpwd_pkg::frame_rec_t   push_rec,
    input  logic                    pop,
    output dfpwd_pkg::frame_rec_t   head_rec,
    output dfpwd_pkg::queue_flags_t q_flags
);

    localparam int DEPTH = dfpwd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dfpwd_pkg::frame_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign q_flags.full  = (cnt_reg == CNT_FULL);
    assign q_flags.empty = (cnt_reg == '0);
    assign do_push = push && !q_flags.full;
    assign do_pop  = pop && !q_flags.empty;
    assign head_rec = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)  rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)      cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push) cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_rec;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("queue count overflow");

    a_no_lost_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_flags.full)
        else $error("record pushed into full queue");

    a_no_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_flags.empty)
        else $error("pop from empty queue");

endmodule

### src/dfpwd_back.sv
// Back end: id match, wheel-count deltas and the registered result stage.
// Depends on dfpwd_pkg; holds the odometry id register and previous counts.
module dfpwd_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [31:0]                     cfg_wdata,
    input  dfpwd_pkg::frame_rec_t           head_rec,
    input  dfpwd_pkg::queue_flags_t         q_flags,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dfpwd_pkg::OUT_TUSER_W-1:0] m_tuser,
    output logic [dfpwd_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic [31:0] odom_id_reg;
    logic [31:0] prev_left_reg, prev_right_reg;
    logic        seen_reg;
    logic        valid_reg, valid_next;

    dfpwd_pkg::frame_status_t status_reg, status_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] lc_reg, lc_next;
    logic [31:0] rc_reg, rc_next;
    logic [31:0] ld_reg, ld_next;
    logic [31:0] rd_reg, rd_next;
    logic [31:0] base_left, base_right;
    logic        odom_hit;

    // Take the next record whenever the output stage is free or draining
    assign pop = !q_flags.empty && (!valid_reg || m_tready);

    assign odom_hit   = !head_rec.too_short && !head_rec.csum_bad
                        && (head_rec.message_id == odom_id_reg);
    assign base_left  = seen_reg ? prev_left_reg  : head_rec.left_count;
    assign base_right = seen_reg ? prev_right_reg : head_rec.right_count;

    always_comb begin
        status_next = dfpwd_pkg::ST_ODOM_OK;
        id_next     = '0;
        lc_next     = '0;
        rc_next     = '0;
        ld_next     = '0;
        rd_next     = '0;
        if (head_rec.too_short) begin
            status_next = dfpwd_pkg::ST_TOO_SHORT;
        end else if (head_rec.csum_bad) begin
            status_next = dfpwd_pkg::ST_CSUM_BAD;
        end else if (!odom_hit) begin
            status_next = dfpwd_pkg::ST_OTHER_ID;
            id_next     = head_rec.message_id;
        end else begin
            id_next = head_rec.message_id;
            lc_next = head_rec.left_count;
            rc_next = head_rec.right_count;
            ld_next = head_rec.left_count - base_left;
            rd_next = head_rec.right_count - base_right;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (pop)           valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            odom_id_reg    <= dfpwd_pkg::ODOM_ID_RESET;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            seen_reg       <= 1'b0;
            valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) odom_id_reg <= cfg_wdata;
            if (pop && odom_hit) begin
                prev_left_reg  <= head_rec.left_count;
                prev_right_reg <= head_rec.right_count;
                seen_reg       <= 1'b1;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg <= status_next;
            id_reg     <= id_next;
            lc_reg     <= lc_next;
            rc_reg     <= rc_next;
            ld_reg     <= ld_next;
            rd_reg     <= rd_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {rd_reg, ld_reg, rc_reg, lc_reg, id_reg};

    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(seen_reg) |-> valid_reg && ld_reg == '0 && rd_reg == '0)
        else $error("first odometry frame gave nonzero delta");

    a_seen_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |=> seen_reg)
        else $error("seen flag cleared");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && status_reg != dfpwd_pkg::ST_ODOM_OK |-> lc_reg == '0 && ld_reg == '0)
        else $error("counts present on non-odometry result");

endmodule

### src/dle_frame_parser_wheel_deltas.sv
// Top level of the DLE-STX/DLE-ETX deframer with XOR check and wheel deltas.
// Depends on dfpwd_pkg, dfpwd_front, dfpwd_queue and dfpwd_back.
//
//  Channel   Direction  Payload (low bit up)                                Handshake
//  s_*       in         tdata[7:0] rx_byte                                  tvalid/tready
//  m_*       out        tuser[1:0] frame_status; tdata[159:0] message_id,   tvalid/tready
//                       left/right_count, left/right_delta
//  cfg_*     in         cfg_wdata[31:0] odometry_message_id                 cfg_we
//
// One received byte is taken every cycle while the queue has room; frame bytes
// are never stalled by the parser itself. After its ETX byte the result of a frame
// goes out through registers: the front pushes a record into a two-entry queue, the back registers the result.
// s_tready drops only while the queue is full, i.e. when two frame results
// wait behind a stalled m_tready. Reset (aresetn low, synchronous) returns the
// parser to waiting for DLE, empties the queue and forgets the previous counts.
module dle_frame_parser_wheel_deltas #(
    parameter int BUFFER_DEPTH = dfpwd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: odometry_message_id
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [dfpwd_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] rx_byte
    // frame results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [dfpwd_pkg::OUT_TUSER_W-1:0] m_tuser,  // [1:0] frame_status
    // [31:0] message_id, [63:32] left_count, [95:64] right_count,
    // [127:96] left_delta, [159:128] right_delta
    output logic [dfpwd_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // Records cross from the parser to the result stage through the queue
    logic                    push;
    logic                    pop;
    dfpwd_pkg::frame_rec_t   push_rec;
    dfpwd_pkg::frame_rec_t   head_rec;
    dfpwd_pkg::queue_flags_t q_flags;

    // Parse, drop overflow bytes, track XOR and capture id and counters
    dfpwd_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_flags  (q_flags),
        .push     (push),
        .push_rec (push_rec)
    );

    // Hold finished frames while the result side stalls
    dfpwd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .q_flags  (q_flags)
    );

    // Match id, compute deltas against stored counts, drive the result
    dfpwd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head_rec  (head_rec),
        .q_flags   (q_flags),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

endmodule

### tb/sv/tb_dle_frame_parser_wheel_deltas.sv
// Self-checking testbench for dle_frame_parser_wheel_deltas: byte-stuffed frames in,
// classified frame results with wheel-count deltas out, checked against a local predictor.
// Depends on dfpwd_pkg and the RTL of the block; reads no files.
module tb_dle_frame_parser_wheel_deltas;

    timeunit 1ns;
    timeprecision 1ps;

    import dfpwd_pkg::*;

    localparam int STORE_SLOTS   = BUFFER_DEPTH_DEF - 1;  // bytes kept per frame
    localparam int SETTLE_CYCLES = 8;                     // idle margin after the last result
    localparam int DRAIN_LIMIT   = 50000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BYTES   = 260;

    // One expected frame result, fields as they sit in m_tuser and m_tdata
    typedef struct packed {
        frame_status_t status;
        logic [31:0]   msg_id;
        logic [31:0]   left_count;
        logic [31:0]   right_count;
        logic [31:0]   left_delta;
        logic [31:0]   right_delta;
    } frame_result_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = '0;   // [7:0] rx_byte
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [OUT_TUSER_W-1:0] m_tuser;  // [1:0] frame_status
    // [31:0] message_id, [63:32] left_count, [95:64] right_count,
    // [127:96] left_delta, [159:128] right_delta
    logic [OUT_TDATA_W-1:0] m_tdata;

    always #2 aclk = ~aclk;

    dle_frame_parser_wheel_deltas uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------
    // Deframer predictor: its own parse state, frame store, counts and id
    // ------------------------------------------------------------------
    parse_phase_t  rx_phase = PH_WAIT_DLE;
    int            rx_fill  = 0;
    logic [7:0]    rx_store [STORE_SLOTS];
    logic [31:0]   odom_id  = ODOM_ID_RESET;
    logic [31:0]   pred_left  = '0;
    logic [31:0]   pred_right = '0;
    bit            counts_known = 1'b0;

    frame_result_t frame_results[$];   // predicted results, oldest first
    logic [7:0]    rx_pending[$];      // bytes waiting for the sender

    int mismatches    = 0;
    int results_seen  = 0;
    int status_hits[4] = '{0, 0, 0, 0};
    int bytes_queued  = 0;
    int bytes_taken   = 0;
    int id_writes     = 0;
    int held_inputs   = 0;
    logic hold_active = 1'b0;

    // Generator-side memory of the last counts sent, used to pick nearby values
    logic [31:0] gen_left  = '0;
    logic [31:0] gen_right = '0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Append a byte to the frame store; drop it once the store is full
    function automatic void keep_byte(input logic [7:0] b);
        if (rx_fill < STORE_SLOTS) begin
            rx_store[rx_fill] = b;
            rx_fill++;
        end
    endfunction

    // Classify the stored frame at DLE ETX and update the previous counts
    function automatic frame_result_t close_frame();
        frame_result_t r;
        logic [7:0]    sum;
        logic [31:0]   id;
        logic [31:0]   lc;
        logic [31:0]   rc;
        r = '0;
        if (rx_fill < MIN_FRAME_LEN) begin
            r.status = ST_TOO_SHORT;
            return r;
        end
        sum = '0;
        for (int i = 0; i < rx_fill - 1; i++)
            sum ^= rx_store[i];
        if (sum != rx_store[rx_fill-1]) begin
            r.status = ST_CSUM_BAD;
            return r;
        end
        id = {rx_store[4], rx_store[3], rx_store[2], rx_store[1]};
        r.msg_id = id;
        if (id != odom_id) begin
            r.status = ST_OTHER_ID;
            return r;
        end
        // counters travel as two big-endian halves, low half first
        lc = {rx_store[9], rx_store[10], rx_store[7], rx_store[8]};
        rc = {rx_store[13], rx_store[14], rx_store[11], rx_store[12]};
        if (!counts_known) begin
            counts_known = 1'b1;
            pred_left    = lc;
            pred_right   = rc;
        end
        r.status      = ST_ODOM_OK;
        r.left_count  = lc;
        r.right_count = rc;
        r.left_delta  = lc - pred_left;
        r.right_delta = rc - pred_right;
        pred_left  = lc;
        pred_right = rc;
        return r;
    endfunction

    // Advance the parse state by one accepted byte
    function automatic void take_rx_byte(input logic [7:0] b);
        case (rx_phase)
            PH_WAIT_DLE: begin
                if (b == SYM_DLE) rx_phase = PH_WAIT_STX;
            end
            PH_WAIT_STX: begin
                if (b == SYM_STX) rx_phase = PH_BODY;
                rx_fill = 0;
            end
            PH_BODY: begin
                if (b == SYM_DLE) rx_phase = PH_BODY_ESC;
                else keep_byte(b);
            end
            default: begin
                if (b == SYM_ETX) begin
                    rx_phase = PH_WAIT_DLE;
                    frame_results.push_back(close_frame());
                end else begin
                    keep_byte(b);
                    rx_phase = PH_BODY;
                end
            end
        endcase
    endfunction

    // Idle length: mostly none or short, now and then long; none in steady stretches
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_rx(input logic [7:0] b);
        rx_pending.push_back(b);
        bytes_queued++;
    endtask

    // Build a frame of len body bytes with the id and counts at their offsets,
    // put the XOR check into the last byte that will be kept, then stuff and wrap it.
    task automatic queue_frame(input logic [31:0] id, input logic [31:0] lc,
                               input logic [31:0] rc, input int len, input bit bad_sum);
        logic [7:0] body[$];
        logic [7:0] b;
        logic [7:0] sum;
        int         stored;
        for (int i = 0; i < len; i++) begin
            case (i)
                1:       b = id[7:0];
                2:       b = id[15:8];
                3:       b = id[23:16];
                4:       b = id[31:24];
                7:       b = lc[15:8];
                8:       b = lc[7:0];
                9:       b = lc[31:24];
                10:      b = lc[23:16];
                11:      b = rc[15:8];
                12:      b = rc[7:0];
                13:      b = rc[31:24];
                14:      b = rc[23:16];
                default: b = $urandom_range(0, 255);
            endcase
            body.push_back(b);
        end
        stored = (len < STORE_SLOTS) ? len : STORE_SLOTS;
        if (stored > 0) begin
            sum = '0;
            for (int i = 0; i < stored - 1; i++)
                sum ^= body[i];
            body[stored-1] = bad_sum ? sum ^ (8'd1 << $urandom_range(0, 7)) : sum;
        end
        push_rx(SYM_DLE);
        push_rx(SYM_STX);
        foreach (body[i]) begin
            // escape every DLE, and some other bytes too (never ETX: that would end it)
            if (body[i] == SYM_DLE || (body[i] != SYM_ETX && $urandom_range(0, 7) == 0))
                push_rx(SYM_DLE);
            push_rx(body[i]);
        end
        push_rx(SYM_DLE);
        push_rx(SYM_ETX);
    endtask

    function automatic logic [31:0] pick_count(input logic [31:0] prev);
        case ($urandom_range(0, 3))
            0: return prev + $urandom_range(0, 2000) - 1000;
            1: return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return prev + ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        endcase
    endfunction

    // Mostly well-formed frames for the current id with random content; the rest
    // is bad checksums, foreign ids, short frames, line noise and cut-off frames.
    task automatic queue_random_traffic(input int n_bytes);
        int start;
        int kind;
        int len;
        logic [31:0] other;
        start = bytes_queued;
        while (bytes_queued - start < n_bytes) begin
            kind = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(16, STORE_SLOTS + 12)
                                               : $urandom_range(16, 24);
            if (kind < 55) begin
                gen_left  = pick_count(gen_left);
                gen_right = pick_count(gen_right);
                queue_frame(odom_id, gen_left, gen_right, len, 1'b0);
            end else if (kind < 65) begin
                queue_frame(odom_id, $urandom, $urandom, len, 1'b1);
            end else if (kind < 75) begin
                other = odom_id ^ ($urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31))
                                                        : ($urandom | 32'd1));
                queue_frame(other, $urandom, $urandom, len, 1'b0);
            end else if (kind < 83) begin
                queue_frame($urandom, $urandom, $urandom, $urandom_range(0, 15), 1'b0);
            end else if (kind < 93) begin
                // noise, then DLE ETX to fall back to hunting for a start
                repeat ($urandom_range(1, 12))
                    push_rx(($urandom_range(0, 3) == 0) ? SYM_DLE : 8'($urandom_range(0, 255)));
                push_rx(SYM_DLE);
                push_rx(SYM_ETX);
            end else begin
                // start a frame and never end it; the next frame gets merged into it
                push_rx(SYM_DLE);
                push_rx(SYM_STX);
                repeat ($urandom_range(1, 10))
                    push_rx(8'($urandom_range(0, 255)) & 8'hEF);
            end
        end
    endtask

    // Wait for the sender to run dry and every expected result to arrive,
    // then give the block its pipeline latency before touching the register.
    task automatic wait_idle();
        int waited;
        waited = 0;
        while ((rx_pending.size() != 0 || s_tvalid || frame_results.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (frame_results.size() != 0) begin
            report_mismatch($sformatf("%0d frame results never arrived", frame_results.size()));
            frame_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_odometry_id(input logic [31:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        odom_id = value;
        id_writes++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued bytes, update the predictor on every transaction
    // ------------------------------------------------------------------
    int send_gap   = 0;
    int send_quiet = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_rx_byte(s_tdata);
                bytes_taken++;
            end
            // hold the byte on offer until it is taken
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (rx_pending.size() > 0) begin
                    s_tdata  <= rx_pending.pop_front();
                    s_tvalid <= 1'b1;
                    if (send_quiet > 0) send_quiet--;
                    else if ($urandom_range(0, 399) == 0) send_quiet = 150;
                    send_gap = pick_gap(send_quiet > 0);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, forced low during the hold-off
    // ------------------------------------------------------------------
    int recv_stall = 0;
    int recv_quiet = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_active) begin
            m_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (recv_quiet > 0) recv_quiet--;
            else if ($urandom_range(0, 299) == 0) recv_quiet = 120;
            recv_stall = ($urandom_range(0, 2) == 0) ? pick_gap(recv_quiet > 0) : 0;
        end
    end

    // Long hold-off while the sender keeps going: the result queue fills
    // and the block must drop s_tready until the receiver returns.
    initial begin : hold_off
        // start early in the second traffic phase, with plenty of bytes queued
        wait (id_writes >= 1);
        repeat (20) @(posedge aclk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) begin
            @(posedge aclk);
            if (!s_tready) held_inputs++;
        end
        hold_active <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transaction with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge aclk) begin : result_monitor
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, tuser %h tdata %h",
                                          m_tuser, m_tdata));
            end else begin
                want = frame_results.pop_front();
                check_field("frame_status", 32'(m_tuser[1:0]),    32'(want.status));
                check_field("message_id",   m_tdata[31:0],        want.msg_id);
                check_field("left_count",   m_tdata[63:32],       want.left_count);
                check_field("right_count",  m_tdata[95:64],       want.right_count);
                check_field("left_delta",   m_tdata[127:96],      want.left_delta);
                check_field("right_delta",  m_tdata[159:128],     want.right_delta);
                status_hits[want.status]++;
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed frames, then random traffic under several ids
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, with the id left at its reset value.
        // Line noise while hunting for DLE, then an empty frame.
        push_rx(8'h03); push_rx(8'h02); push_rx(8'hFF); push_rx(8'h00);
        queue_frame(ODOM_ID_RESET, '0, '0, 0, 1'b0);
        // First odometry frame: deltas start at zero.
        queue_frame(ODOM_ID_RESET, 32'hFFFF_FFFF, 32'h0000_0000, 16, 1'b0);
        // Wrap in both directions.
        queue_frame(ODOM_ID_RESET, 32'h0000_0000, 32'h8000_0000, 16, 1'b0);
        // Counters full of DLE, ETX and STX values, all of which must survive stuffing.
        queue_frame(ODOM_ID_RESET, 32'h1010_1010, 32'h0302_1003, 20, 1'b0);
        queue_frame(ODOM_ID_RESET, 32'h7FFF_FFFF, 32'h8000_0001, 16, 1'b1);
        queue_frame(32'hFFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0, 18, 1'b0);
        queue_frame(ODOM_ID_RESET ^ 32'h8000_0000, $urandom, $urandom, 17, 1'b0);
        queue_frame(ODOM_ID_RESET, $urandom, $urandom, 15, 1'b0);
        // Store exactly full, then overfull with the tail dropped.
        queue_frame(ODOM_ID_RESET, 32'h0000_0001, 32'hFFFF_FFFF, STORE_SLOTS, 1'b0);
        queue_frame(ODOM_ID_RESET, 32'h8000_0000, 32'h0000_0000, STORE_SLOTS + 14, 1'b0);
        // DLE followed by junk instead of STX: keep waiting for STX.
        push_rx(SYM_DLE); push_rx(8'h55); push_rx(SYM_DLE);
        queue_frame(ODOM_ID_RESET, 32'h0000_0000, 32'h7FFF_FFFF, 16, 1'b0);
        gen_left  = 32'h0000_0000;
        gen_right = 32'h7FFF_FFFF;
        queue_random_traffic(PHASE_BYTES / 2);
        wait_idle();

        set_odometry_id(32'h0000_0000);
        queue_random_traffic(PHASE_BYTES);
        wait_idle();

        set_odometry_id(32'hFFFF_FFFF);
        queue_random_traffic(PHASE_BYTES);
        wait_idle();

        set_odometry_id($urandom);
        queue_random_traffic(PHASE_BYTES);
        wait_idle();

        set_odometry_id(ODOM_ID_RESET);
        queue_random_traffic(PHASE_BYTES);
        wait_idle();

        $display("Covered %0d bytes and %0d frames: %0d odometry, %0d bad check,",
                 bytes_taken, results_seen, status_hits[ST_ODOM_OK], status_hits[ST_CSUM_BAD]);
        $display("%0d other id, %0d short; wrote %0d odometry ids; input stalled %0d cycles",
                 status_hits[ST_OTHER_ID], status_hits[ST_TOO_SHORT], id_writes, held_inputs);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
src/dfpwd_pkg.sv
src/dfpwd_front.sv
src/dfpwd_queue.sv
src/dfpwd_back.sv
src/dle_frame_parser_wheel_deltas.sv
tb/sv/tb_dle_frame_parser_wheel_deltas.sv
